>>> rtl/sha1_pkg.sv
`timescale 1ns / 1ps

package sha1_pkg;

    // SHA-1 initial hash values
    localparam logic [31:0] H0_INIT = 32'h67452301;
    localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
    localparam logic [31:0] H2_INIT = 32'h98BADCFE;
    localparam logic [31:0] H3_INIT = 32'h10325476;
    localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

    // Round constants, one per group of twenty rounds
    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam int ROUNDS     = 80;
    localparam int HASH_WORDS = 5;
    localparam int BLOCK_WRDS = 16;
    localparam int COUNT_W    = 61;

    typedef logic [6:0] t_round;
    typedef logic [2:0] t_word_sel;

    localparam t_round    LAST_ROUND = t_round'(ROUNDS - 1);
    localparam t_word_sel LAST_WORD  = t_word_sel'(HASH_WORDS - 1);

    // Input transaction payload
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
    } t_in_item;

    // Output transaction payload
    typedef struct packed {
        logic [31:0] digest_word;
        logic        word_last;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic      wr_byte;
        logic      pad;
        logic      len_blk;
        logic      start;
        logic      round;
        logic      fin;
        logic      reload;
        t_word_sel out_sel;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic pos_last;
        logic pos_high;
        logic round_last;
    } t_dp_stat;

endpackage

>>> rtl/sha1_datapath.sv
`timescale 1ns / 1ps

module sha1_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [7:0]          i_data_byte,
    input  sha1_pkg::t_dp_cmd   i_cmd,
    output sha1_pkg::t_dp_stat  o_stat,
    output logic [31:0]         o_digest_word
);

    logic [31:0] r_w [sha1_pkg::BLOCK_WRDS];
    logic [31:0] n_w [sha1_pkg::BLOCK_WRDS];
    logic [31:0] r_h [sha1_pkg::HASH_WORDS];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [sha1_pkg::COUNT_W-1:0] r_count;
    sha1_pkg::t_round r_t;

    logic [5:0]  pos;
    logic [63:0] bit_len;
    logic [31:0] f_val, k_val, tmp, w_new;

    assign pos     = r_count[5:0];
    assign bit_len = {r_count, 3'b000};

    // Report fill position and round progress
    assign o_stat.pos_last   = (pos == 6'd63);
    assign o_stat.pos_high   = (pos >= 6'd56);
    assign o_stat.round_last = (r_t == sha1_pkg::LAST_ROUND);

    assign o_digest_word = r_h[i_cmd.out_sel];

    // Round function and constant by round group
    always_comb begin
        if (r_t < 7'd20) begin
            f_val = (r_b & r_c) | (~r_b & r_d);
            k_val = sha1_pkg::K0;
        end else if (r_t < 7'd40) begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = sha1_pkg::K1;
        end else if (r_t < 7'd60) begin
            f_val = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k_val = sha1_pkg::K2;
        end else begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = sha1_pkg::K3;
        end
        tmp   = {r_a[26:0], r_a[31:27]} + f_val + r_e + k_val + r_w[0];
        w_new = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
        w_new = {w_new[30:0], w_new[31]};
    end

    // Next block words: byte write, padding, length block or schedule shift
    always_comb begin
        for (int i = 0; i < sha1_pkg::BLOCK_WRDS; i++) begin
            n_w[i] = r_w[i];
        end
        if (i_cmd.wr_byte) begin
            n_w[pos[5:2]][8*(3 - pos[1:0]) +: 8] = i_data_byte;
        end
        if (i_cmd.pad) begin
            for (int i = 0; i < sha1_pkg::BLOCK_WRDS; i++) begin
                if (4'(i) > pos[5:2]) begin
                    n_w[i] = 32'd0;
                end else if (4'(i) == pos[5:2]) begin
                    for (int j = 0; j < 4; j++) begin
                        if (2'(j) == pos[1:0]) begin
                            n_w[i][8*(3 - j) +: 8] = sha1_pkg::PAD_BYTE;
                        end else if (2'(j) > pos[1:0]) begin
                            n_w[i][8*(3 - j) +: 8] = 8'd0;
                        end
                    end
                end
            end
            if (!o_stat.pos_high) begin
                n_w[14] = bit_len[63:32];
                n_w[15] = bit_len[31:0];
            end
        end
        if (i_cmd.len_blk) begin
            for (int i = 0; i < sha1_pkg::BLOCK_WRDS - 2; i++) begin
                n_w[i] = 32'd0;
            end
            n_w[14] = bit_len[63:32];
            n_w[15] = bit_len[31:0];
        end
        if (i_cmd.round) begin
            for (int i = 0; i < sha1_pkg::BLOCK_WRDS - 1; i++) begin
                n_w[i] = r_w[i + 1];
            end
            n_w[15] = w_new;
        end
    end

    // Hold block words and working variables
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < sha1_pkg::BLOCK_WRDS; i++) begin
            r_w[i] <= n_w[i];
        end
        if (i_cmd.start) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
        end else if (i_cmd.round) begin
            r_a <= tmp;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
    end

    // Hold hash state, byte count and round counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h[0]  <= sha1_pkg::H0_INIT;
            r_h[1]  <= sha1_pkg::H1_INIT;
            r_h[2]  <= sha1_pkg::H2_INIT;
            r_h[3]  <= sha1_pkg::H3_INIT;
            r_h[4]  <= sha1_pkg::H4_INIT;
            r_count <= '0;
            r_t     <= '0;
        end else begin
            if (i_cmd.reload) begin
                r_h[0]  <= sha1_pkg::H0_INIT;
                r_h[1]  <= sha1_pkg::H1_INIT;
                r_h[2]  <= sha1_pkg::H2_INIT;
                r_h[3]  <= sha1_pkg::H3_INIT;
                r_h[4]  <= sha1_pkg::H4_INIT;
                r_count <= '0;
            end else begin
                if (i_cmd.fin) begin
                    r_h[0] <= r_h[0] + r_a;
                    r_h[1] <= r_h[1] + r_b;
                    r_h[2] <= r_h[2] + r_c;
                    r_h[3] <= r_h[3] + r_d;
                    r_h[4] <= r_h[4] + r_e;
                end
                if (i_cmd.wr_byte) begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (i_cmd.start) begin
                r_t <= '0;
            end else if (i_cmd.round) begin
                r_t <= r_t + 1'b1;
            end
        end
    end

endmodule

>>> rtl/sha1_controller.sv
`timescale 1ns / 1ps

module sha1_controller (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_has_byte,
    input  logic                i_last,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_word_last,
    input  sha1_pkg::t_dp_stat  i_stat,
    output sha1_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROUND,
        S_FINAL,
        S_PAD,
        S_LENBLK,
        S_OUT
    } t_state;

    // Which block is being compressed
    typedef enum logic [1:0] {
        PH_DATA,
        PH_PAD_FIRST,
        PH_LAST
    } t_phase;

    t_state r_state;
    t_phase r_phase;
    logic   r_end;
    logic   r_out_valid;
    sha1_pkg::t_word_sel r_sel;
    logic   in_fire, out_fire;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_fire    = r_out_valid && i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_word_last = (r_sel == sha1_pkg::LAST_WORD);

    // Decode datapath commands
    always_comb begin
        o_cmd         = '0;
        o_cmd.out_sel = r_sel;
        case (r_state)
            S_IDLE: begin
                o_cmd.wr_byte = in_fire && i_has_byte;
                o_cmd.start   = in_fire && i_has_byte && i_stat.pos_last;
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
            end
            S_FINAL: begin
                o_cmd.fin = 1'b1;
            end
            S_PAD: begin
                o_cmd.pad   = 1'b1;
                o_cmd.start = 1'b1;
            end
            S_LENBLK: begin
                o_cmd.len_blk = 1'b1;
                o_cmd.start   = 1'b1;
            end
            S_OUT: begin
                o_cmd.reload = out_fire && (r_sel == sha1_pkg::LAST_WORD);
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // Sequence blocks, padding and digest output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_DATA;
            r_end       <= 1'b0;
            r_out_valid <= 1'b0;
            r_sel       <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_end <= i_last;
                        if (i_has_byte && i_stat.pos_last) begin
                            r_phase <= PH_DATA;
                            r_state <= S_ROUND;
                        end else if (i_last) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_ROUND: begin
                    if (i_stat.round_last) begin
                        r_state <= S_FINAL;
                    end
                end
                S_FINAL: begin
                    case (r_phase)
                        PH_DATA: begin
                            r_state <= r_end ? S_PAD : S_IDLE;
                        end
                        PH_PAD_FIRST: begin
                            r_state <= S_LENBLK;
                        end
                        default: begin
                            r_state     <= S_OUT;
                            r_out_valid <= 1'b1;
                            r_sel       <= '0;
                        end
                    endcase
                end
                S_PAD: begin
                    r_phase <= i_stat.pos_high ? PH_PAD_FIRST : PH_LAST;
                    r_state <= S_ROUND;
                end
                S_LENBLK: begin
                    r_phase <= PH_LAST;
                    r_state <= S_ROUND;
                end
                S_OUT: begin
                    if (out_fire) begin
                        if (r_sel == sha1_pkg::LAST_WORD) begin
                            r_out_valid <= 1'b0;
                            r_end       <= 1'b0;
                            r_state     <= S_IDLE;
                        end else begin
                            r_sel <= r_sel + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/sha1_message_digest_core.sv
`timescale 1ns / 1ps

// SHA-1 digest over a byte stream. Each input transaction carries one byte
// (has_byte) and/or an end-of-message mark (last); an item with only last set
// hashes the empty message. The 64th byte of a block starts its compression
// (80 rounds at one per cycle in the shared round unit, then one hash update;
// the working registers load on the accepting edge) before the next item is
// taken. On the last item the core pads and loads, compresses the final
// block, and also builds and compresses a length block when the padding spills
// into a second block, then presents the five digest words H0..H4 as five
// output transactions, word_last set on the fifth. After the fifth word is
// taken the hash and byte count reload for the next message. Input ready is
// held low while a block is compressed or the digest is being delivered.
module sha1_message_digest_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  sha1_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output sha1_pkg::t_out_item o_out_item
);

    sha1_pkg::t_dp_cmd  dp_cmd;
    sha1_pkg::t_dp_stat dp_stat;
    logic               word_last;
    logic [31:0]        digest_word;

    sha1_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_has_byte  (i_in_item.has_byte),
        .i_last      (i_in_item.last),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_word_last (word_last),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    sha1_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_data_byte   (i_in_item.data_byte),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .o_digest_word (digest_word)
    );

    // Pack the output transaction
    assign o_out_item.digest_word = digest_word;
    assign o_out_item.word_last   = word_last;

endmodule

>>> bench/sha1_digest_checker.sv
`timescale 1ns / 1ps

module sha1_digest_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  sha1_pkg::t_in_item  i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  sha1_pkg::t_out_item i_out_item,
    output int                  o_fail_count,
    output int                  o_pending
);

    // Predicted SHA-1 state: chaining value, block buffer, message byte count
    logic [31:0]                  hash_st [sha1_pkg::HASH_WORDS];
    logic [7:0]                   blk_st [64];
    logic [sha1_pkg::COUNT_W-1:0] byte_cnt;

    sha1_pkg::t_out_item digest_queue [$];

    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    // Run the 80 rounds over the gathered block and fold into the chaining value
    function automatic void compress_block();
        logic [31:0] w [sha1_pkg::ROUNDS];
        logic [31:0] a, b, c, d, e, f, k, tmp;
        for (int t = 0; t < sha1_pkg::BLOCK_WRDS; t++) begin
            w[t] = {blk_st[4*t], blk_st[4*t+1], blk_st[4*t+2], blk_st[4*t+3]};
        end
        for (int t = sha1_pkg::BLOCK_WRDS; t < sha1_pkg::ROUNDS; t++) begin
            w[t] = rotl(w[t-3] ^ w[t-8] ^ w[t-14] ^ w[t-16], 1);
        end
        a = hash_st[0];
        b = hash_st[1];
        c = hash_st[2];
        d = hash_st[3];
        e = hash_st[4];
        for (int t = 0; t < sha1_pkg::ROUNDS; t++) begin
            if (t < 20) begin
                f = (b & c) | (~b & d);
                k = sha1_pkg::K0;
            end else if (t < 40) begin
                f = b ^ c ^ d;
                k = sha1_pkg::K1;
            end else if (t < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = sha1_pkg::K2;
            end else begin
                f = b ^ c ^ d;
                k = sha1_pkg::K3;
            end
            tmp = rotl(a, 5) + f + e + k + w[t];
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = tmp;
        end
        hash_st[0] = hash_st[0] + a;
        hash_st[1] = hash_st[1] + b;
        hash_st[2] = hash_st[2] + c;
        hash_st[3] = hash_st[3] + d;
        hash_st[4] = hash_st[4] + e;
    endfunction

    function automatic void load_initial_hash();
        hash_st[0] = sha1_pkg::H0_INIT;
        hash_st[1] = sha1_pkg::H1_INIT;
        hash_st[2] = sha1_pkg::H2_INIT;
        hash_st[3] = sha1_pkg::H3_INIT;
        hash_st[4] = sha1_pkg::H4_INIT;
        byte_cnt   = '0;
    endfunction

    // Absorb one input transaction; on the end mark pad, finish and queue the digest
    function automatic void absorb_item(input sha1_pkg::t_in_item it);
        int                  pos;
        logic [63:0]         bit_len;
        sha1_pkg::t_out_item word;
        if (it.has_byte) begin
            pos = int'(byte_cnt[5:0]);
            blk_st[pos] = it.data_byte;
            byte_cnt = byte_cnt + 1'b1;
            if (pos == 63) begin
                compress_block();
            end
        end
        if (!it.last) begin
            return;
        end
        pos = int'(byte_cnt[5:0]);
        blk_st[pos] = sha1_pkg::PAD_BYTE;
        for (int i = pos + 1; i < 64; i++) begin
            blk_st[i] = 8'h00;
        end
        // Length field does not fit: spill into a second block
        if (pos >= 56) begin
            compress_block();
            for (int i = 0; i < 56; i++) begin
                blk_st[i] = 8'h00;
            end
        end
        bit_len = {byte_cnt, 3'b000};
        for (int i = 0; i < 8; i++) begin
            blk_st[56+i] = bit_len[(7-i)*8 +: 8];
        end
        compress_block();
        for (int i = 0; i < sha1_pkg::HASH_WORDS; i++) begin
            word.digest_word = hash_st[i];
            word.word_last   = (i == sha1_pkg::HASH_WORDS - 1);
            digest_queue.push_back(word);
        end
        load_initial_hash();
    endfunction

    // Compare delivered digest words, then absorb the accepted input
    always @(posedge i_clk) begin
        sha1_pkg::t_out_item want;
        if (!i_rst_n) begin
            load_initial_hash();
            digest_queue.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (digest_queue.size() == 0) begin
                    $error("unexpected digest word %h with no transaction pending",
                           i_out_item.digest_word);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = digest_queue.pop_front();
                    if (i_out_item.digest_word !== want.digest_word) begin
                        $error("digest_word mismatch: expected %h, actual %h",
                               want.digest_word, i_out_item.digest_word);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_out_item.word_last !== want.word_last) begin
                        $error("word_last mismatch: expected %b, actual %b",
                               want.word_last, i_out_item.word_last);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                absorb_item(i_in_item);
            end
        end
        o_pending = digest_queue.size();
    end

endmodule

>>> bench/sha1_message_digest_core_tb.sv
`timescale 1ns / 1ps

module sha1_message_digest_core_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 600;
    localparam int ITEM_TARGET = 470;
    localparam int MIN_MSGS    = 12;
    localparam int HOLD_MSG    = 3;
    localparam int PAUSE_MSG   = 6;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    sha1_pkg::t_in_item  in_item;
    logic                out_valid;
    logic                out_ready;
    sha1_pkg::t_out_item out_item;

    int fail_count;
    int pending;
    int cycle_count;
    int msg_items;
    int msg_total;
    bit idle_on;
    bit hold_req;

    int boundary_lens [8] = '{55, 56, 57, 63, 64, 65, 119, 120};

    sha1_message_digest_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    sha1_digest_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Abort on a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Drive output ready: random gaps, plus one long hold-off once a digest waits
    initial begin
        int gap_left;
        bit hold_done;
        gap_left  = 0;
        hold_done = 1'b0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (gap_left > 0) begin
                out_ready <= 1'b0;
                gap_left = gap_left - 1;
            end else if (hold_req && !hold_done && out_valid) begin
                hold_done = 1'b1;
                gap_left  = LONG_HOLD - 1;
                out_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                gap_left = $urandom_range(1, 7) - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Offer one transaction, with an optional idle burst ahead of it
    task automatic send_item(input logic [7:0] data, input logic has_byte, input logic last);
        int gap;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid          <= 1'b1;
        in_item.data_byte <= data;
        in_item.has_byte  <= has_byte;
        in_item.last      <= last;
        do begin
            @(posedge clk);
        end while (!in_ready);
        msg_items = msg_items + 1;
    endtask

    // Send a message of len bytes, with stray empty transactions mixed in
    task automatic send_message(input int len);
        logic [7:0] data;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
            data = 8'($urandom_range(0, 255));
            if (i == len - 1 && $urandom_range(0, 1) == 1) begin
                send_item(data, 1'b1, 1'b1);
                msg_total = msg_total + 1;
                return;
            end
            send_item(data, 1'b1, 1'b0);
        end
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        msg_total = msg_total + 1;
    endtask

    initial begin
        int len;
        int sel;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_item     = '0;
        msg_items   = 0;
        msg_total   = 0;
        idle_on     = 1'b1;
        hold_req    = 1'b0;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Empty message, stray item, empty message with ignored data
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b1);
        // "abc", end mark riding on the last byte
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        // Single bytes at both extremes
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hA5, 1'b0, 1'b1);

        // Random messages, biased toward short lengths and block boundaries
        while (msg_items < ITEM_TARGET || msg_total < MIN_MSGS) begin
            if (msg_total == HOLD_MSG) begin
                hold_req = 1'b1;
            end
            // Drop valid and wait until every digest word has come back
            if (msg_total == PAUSE_MSG) begin
                @(negedge clk);
                in_valid <= 1'b0;
                wait (pending == 0);
            end
            if (msg_items >= ITEM_TARGET - 80) begin
                idle_on = 1'b0;
            end
            sel = $urandom_range(0, 9);
            if (sel < 5) begin
                len = $urandom_range(0, 6);
            end else if (sel < 7) begin
                len = boundary_lens[$urandom_range(0, 7)];
            end else begin
                len = $urandom_range(0, 140);
            end
            // Keep the run close to the item budget
            if (len > ITEM_TARGET - msg_items) begin
                len = (msg_items < ITEM_TARGET) ? ITEM_TARGET - msg_items : 0;
            end
            send_message(len);
        end

        @(negedge clk);
        in_valid <= 1'b0;

        // Drain, then allow the compressor to settle
        wait (pending == 0);
        repeat (200) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/sha1_pkg.sv
rtl/sha1_datapath.sv
rtl/sha1_controller.sv
rtl/sha1_message_digest_core.sv
bench/sha1_digest_checker.sv
bench/sha1_message_digest_core_tb.sv
